[design/twodo_pkg.sv]
// Shared types, constants and helpers for the tracking wheel odometry block.
// Used by the serial multiplier, serial divider, CORDIC unit and top level.
// No dependencies.
package twodo_pkg;

    // Fixed-point constants
    localparam int DEG2RAD_Q24  = 292818;
    localparam int RAD2DEG_Q16  = 3754936;
    localparam int PI_Q24       = 52707179;
    localparam int HALF_PI_Q24  = 26353589;
    localparam int TWO_PI_Q24   = 105414357;
    localparam int GAIN_Q30     = 652032874;

    // Operating modes
    localparam logic [1:0] MODE_MOTORS = 2'd0;
    localparam logic [1:0] MODE_LEFT   = 2'd1;
    localparam logic [1:0] MODE_RIGHT  = 2'd2;
    localparam logic [1:0] MODE_THREE  = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_RADIUS  = 3'd1;
    localparam logic [2:0] REG_LOFF    = 3'd2;
    localparam logic [2:0] REG_ROFF    = 3'd3;
    localparam logic [2:0] REG_SOFF    = 3'd4;
    localparam logic [2:0] REG_START_X = 3'd5;
    localparam logic [2:0] REG_START_Y = 3'd6;
    localparam logic [2:0] REG_START_H = 3'd7;

    // Status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < $signed(64'hFFFFFFFF80000000)) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    // atan(2^-i) in Q2.30
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            5'd31: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[design/twodo_mul.sv]
// Bit-serial signed multiplier: 64-bit multiplicand times a narrow multiplier,
// one multiplier bit per cycle, MSB first. Depends on twodo_pkg.
module twodo_mul (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [63:0]       a,
    input  logic signed [33:0]       b,
    input  logic [5:0]               nbit,
    output logic signed [63:0]       prod,
    output twodo_pkg::unit_stat_t    stat
);
    import twodo_pkg::*;

    logic signed [63:0] a_reg;
    logic [33:0]        b_reg;
    logic signed [63:0] acc_reg;
    logic [5:0]         cnt_reg;
    logic               first_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [63:0] addend;

    assign addend = b_reg[33] ? a_reg : 64'sd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg     <= a;
                b_reg     <= b << (6'd33 - nbit);
                cnt_reg   <= nbit;
                first_reg <= 1'b1;
                acc_reg   <= 64'sd0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                // sign bit carries negative weight
                if (first_reg) begin
                    acc_reg <= 64'sd0 - addend;
                end else begin
                    acc_reg <= (acc_reg <<< 1) + addend;
                end
                first_reg <= 1'b0;
                b_reg     <= {b_reg[32:0], 1'b0};
                cnt_reg   <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign prod      = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[design/twodo_div.sv]
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// 64-bit dividend, 34-bit divisor. Depends on twodo_pkg.
module twodo_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [63:0]       num,
    input  logic signed [33:0]       den,
    output logic signed [63:0]       quo,
    output twodo_pkg::unit_stat_t    stat
);
    import twodo_pkg::*;

    logic [63:0] nq_reg;
    logic [33:0] d_reg;
    logic [33:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [34:0] trial;
    logic        ge;

    assign trial = {rem_reg, nq_reg[63]};
    assign ge    = (trial >= {1'b0, d_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                nq_reg   <= num[63] ? 64'(-num) : 64'(num);
                d_reg    <= den[33] ? 34'(-den) : 34'(den);
                neg_reg  <= num[63] ^ den[33];
                rem_reg  <= 34'd0;
                cnt_reg  <= 6'd63;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? 34'(trial - {1'b0, d_reg}) : trial[33:0];
                nq_reg  <= {nq_reg[62:0], ge};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo       = neg_reg ? -$signed(nq_reg) : $signed(nq_reg);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[design/twodo_cordic.sv]
// Sine and cosine of a Q10.24 angle: bit-serial reduction modulo 2*pi, quadrant
// fold, then one CORDIC rotation per cycle in Q4.30. Depends on twodo_pkg.
module twodo_cordic #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [33:0]       angle,
    output logic signed [27:0]       cos_q,
    output logic signed [27:0]       sin_q,
    output twodo_pkg::unit_stat_t    stat
);
    import twodo_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MOD  = 2'd1;
    localparam logic [1:0] PH_FOLD = 2'd2;
    localparam logic [1:0] PH_ROT  = 2'd3;

    logic [1:0]         phase_reg;
    logic [33:0]        mag_reg;
    logic               neg_reg;
    logic [26:0]        rem_reg;
    logic [5:0]         cnt_reg;
    logic               flip_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    logic               done_reg;

    logic [27:0]        trial;
    logic signed [27:0] r0;
    logic signed [27:0] r1;
    logic signed [27:0] r2;
    logic               flip;
    logic [4:0]         idx;
    logic signed [33:0] atan_v;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] xo;

    assign trial  = {rem_reg, mag_reg[33]};
    assign idx    = cnt_reg[4:0];
    assign atan_v = $signed({2'b00, atan_q30(idx)});
    assign xs     = x_reg >>> idx;
    assign ys     = y_reg >>> idx;

    always_comb begin
        r0 = (neg_reg && rem_reg != 27'd0) ? 28'(TWO_PI_Q24) - $signed({1'b0, rem_reg})
                                           : $signed({1'b0, rem_reg});
        r1 = (r0 > 28'(PI_Q24)) ? r0 - 28'(TWO_PI_Q24) : r0;
        flip = 1'b0;
        r2   = r1;
        if (r1 > 28'(HALF_PI_Q24)) begin
            r2   = 28'(PI_Q24) - r1;
            flip = 1'b1;
        end else if (r1 < -28'(HALF_PI_Q24)) begin
            r2   = -28'(PI_Q24) - r1;
            flip = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                PH_IDLE: begin
                    if (start) begin
                        mag_reg   <= angle[33] ? 34'(-angle) : 34'(angle);
                        neg_reg   <= angle[33];
                        rem_reg   <= 27'd0;
                        cnt_reg   <= 6'd33;
                        phase_reg <= PH_MOD;
                    end
                end
                PH_MOD: begin
                    rem_reg <= (trial >= 28'(TWO_PI_Q24)) ? 27'(trial - 28'(TWO_PI_Q24))
                                                          : trial[26:0];
                    mag_reg <= {mag_reg[32:0], 1'b0};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0) begin
                        phase_reg <= PH_FOLD;
                    end
                end
                PH_FOLD: begin
                    z_reg     <= 34'(r2) <<< 6;
                    x_reg     <= 34'(GAIN_Q30);
                    y_reg     <= 34'sd0;
                    flip_reg  <= flip;
                    cnt_reg   <= 6'd0;
                    phase_reg <= PH_ROT;
                end
                PH_ROT: begin
                    if (z_reg >= 34'sd0) begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - atan_v;
                    end else begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + atan_v;
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(CORDIC_STEPS - 1)) begin
                        phase_reg <= PH_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    assign xo        = x_reg >>> 6;
    assign cos_q     = flip_reg ? 28'(-xo) : 28'(xo);
    assign sin_q     = 28'(y_reg >>> 6);
    assign stat.busy = (phase_reg != PH_IDLE);
    assign stat.done = done_reg;

endmodule

[design/tracking_wheel_odometry.sv]
// Tracking wheel odometry top level: sequencer around the serial multiplier,
// divider and CORDIC unit, plus the APB register file. Depends on twodo_pkg.
//
// One sample in, one pose out. Each sample's wheel angle deltas become travel
// (angle change * pi/180 * radius); heading comes from the gyro mean or, in
// three-wheel mode, from the left/right travel difference over the track
// width; the local move (straight, or a chord along an arc) is rotated by the
// mid-arc heading and added to the saturating x/y pose. Samples are processed
// one at a time. Three-wheel mode uses the divider in place of the gyro
// product, unless the track width is zero. The processing time of a sample is
// set by three units:
// - the bit-serial multiplier: one multiplier bit per cycle, with 11 to 16
//   products per sample;
// - the 64-step restoring divider: up to three divisions per sample;
// - the CORDIC unit: bit-serial angle reduction, a quadrant fold, then one
//   rotation per cycle.
// The finished pose sits in an output register, so the next sample is taken
// while the previous result waits. Any register write resets the pose to the
// start values; s_ready drops for one cycle after it. There is no clearing
// pass after reset.
module tracking_wheel_odometry #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // sample beats
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_left_angle,
    input  logic signed [31:0] s_right_angle,
    input  logic signed [31:0] s_side_angle,
    input  logic signed [31:0] s_gyro_a,
    input  logic signed [31:0] s_gyro_b,
    // pose beats
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_heading_deg
);
    import twodo_pkg::*;

    // sequencer states
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_TRAV_A = 5'd1;   // delta * radius
    localparam logic [4:0] ST_TRAV_B = 5'd2;   // * pi/180
    localparam logic [4:0] ST_SUMS   = 5'd3;
    localparam logic [4:0] ST_GYRO   = 5'd4;
    localparam logic [4:0] ST_HDIV   = 5'd5;
    localparam logic [4:0] ST_TURN   = 5'd6;
    localparam logic [4:0] ST_HALF   = 5'd7;   // sin of half turn
    localparam logic [4:0] ST_XM     = 5'd8;
    localparam logic [4:0] ST_XD     = 5'd9;
    localparam logic [4:0] ST_XO     = 5'd10;
    localparam logic [4:0] ST_YM     = 5'd11;
    localparam logic [4:0] ST_YD     = 5'd12;
    localparam logic [4:0] ST_YO     = 5'd13;
    localparam logic [4:0] ST_MID    = 5'd14;  // sin/cos of mid heading
    localparam logic [4:0] ST_G1     = 5'd15;
    localparam logic [4:0] ST_G2     = 5'd16;
    localparam logic [4:0] ST_G3     = 5'd17;
    localparam logic [4:0] ST_G4     = 5'd18;
    localparam logic [4:0] ST_DEG    = 5'd19;
    localparam logic [4:0] ST_PUSH   = 5'd20;

    // configuration registers
    logic [1:0]         mode_reg;
    logic [16:0]        radius_reg;
    logic [20:0]        loff_reg;
    logic [20:0]        roff_reg;
    logic signed [21:0] soff_reg;
    logic signed [31:0] sx_reg;
    logic signed [31:0] sy_reg;
    logic signed [31:0] sh_reg;
    logic               clr_pend_reg;

    // model state
    logic signed [31:0] last_left_reg;
    logic signed [31:0] last_right_reg;
    logic signed [31:0] last_side_reg;
    logic signed [31:0] sum_left_reg;
    logic signed [31:0] sum_right_reg;
    logic signed [31:0] last_heading_reg;
    logic signed [31:0] acc_x_reg;
    logic signed [31:0] acc_y_reg;

    // sequencer and working registers
    logic [4:0]         state_reg;
    logic               launched_reg;
    logic [1:0]         wheel_reg;
    logic signed [31:0] in_l_reg;
    logic signed [31:0] in_r_reg;
    logic signed [31:0] in_s_reg;
    logic signed [31:0] in_ga_reg;
    logic signed [31:0] in_gb_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] q_reg;
    logic signed [31:0] dl_reg;
    logic signed [31:0] dr_reg;
    logic signed [31:0] ds_reg;
    logic signed [31:0] h_reg;
    logic signed [32:0] t_reg;
    logic signed [28:0] chord_reg;
    logic signed [27:0] cos_reg;
    logic signed [27:0] sin_reg;
    logic signed [31:0] lx_reg;
    logic signed [31:0] ly_reg;
    logic signed [31:0] deg_reg;

    // output register
    logic               m_valid_reg;
    logic signed [31:0] m_pos_x_reg;
    logic signed [31:0] m_pos_y_reg;
    logic signed [31:0] m_heading_deg_reg;

    // unit hookup
    logic               mul_start;
    logic signed [63:0] mul_a;
    logic signed [33:0] mul_b;
    logic [5:0]         mul_nbit;
    logic signed [63:0] mul_p;
    unit_stat_t         mul_stat;
    logic               div_start;
    logic signed [63:0] div_num;
    logic signed [33:0] div_den;
    logic signed [63:0] div_q;
    unit_stat_t         div_stat;
    logic               cor_start;
    logic signed [33:0] cor_angle;
    logic signed [27:0] cor_c;
    logic signed [27:0] cor_s;
    unit_stat_t         cor_stat;

    logic               use_mul;
    logic               use_div;
    logic               use_cor;
    logic               unit_done;
    logic               cfg_we;
    logic signed [32:0] delta;
    logic signed [31:0] trav;
    logic signed [32:0] turn;
    logic [21:0]        track;

    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;
    assign track  = {1'b0, loff_reg} + {1'b0, roff_reg};
    assign turn   = 33'(h_reg) - 33'(last_heading_reg);
    assign trav   = sat32(mul_p >>> 24);

    always_comb begin
        unique case (wheel_reg)
            2'd0:    delta = 33'(in_l_reg) - 33'(last_left_reg);
            2'd1:    delta = 33'(in_r_reg) - 33'(last_right_reg);
            default: delta = 33'(in_s_reg) - 33'(last_side_reg);
        endcase
    end

    // register read back
    always_comb begin
        unique case (paddr[4:2])
            REG_MODE:    prdata = {30'd0, mode_reg};
            REG_RADIUS:  prdata = {15'd0, radius_reg};
            REG_LOFF:    prdata = {11'd0, loff_reg};
            REG_ROFF:    prdata = {11'd0, roff_reg};
            REG_SOFF:    prdata = 32'(soff_reg);
            REG_START_X: prdata = sx_reg;
            REG_START_Y: prdata = sy_reg;
            REG_START_H: prdata = sh_reg;
            default:     prdata = 32'd0;
        endcase
    end

    // operand selection per sequencer step
    always_comb begin
        use_mul   = 1'b0;
        use_div   = 1'b0;
        use_cor   = 1'b0;
        mul_a     = 64'sd0;
        mul_b     = 34'sd0;
        mul_nbit  = 6'd0;
        div_num   = 64'sd0;
        div_den   = 34'sd1;
        cor_angle = 34'sd0;
        unique case (state_reg)
            ST_TRAV_A: begin
                use_mul  = 1'b1;
                mul_a    = 64'(delta);
                mul_b    = 34'($signed({1'b0, radius_reg}));
                mul_nbit = 6'd17;
            end
            ST_TRAV_B: begin
                use_mul  = 1'b1;
                mul_a    = prod_reg >>> 8;
                mul_b    = 34'(DEG2RAD_Q24);
                mul_nbit = 6'd19;
            end
            ST_GYRO: begin
                use_mul  = 1'b1;
                mul_a    = 64'(33'(in_ga_reg) + 33'(in_gb_reg));
                mul_b    = 34'(DEG2RAD_Q24);
                mul_nbit = 6'd19;
            end
            ST_HDIV: begin
                use_div = 1'b1;
                div_num = 64'(33'(sum_left_reg) - 33'(sum_right_reg)) <<< 24;
                div_den = 34'($signed({1'b0, track}));
            end
            ST_HALF: begin
                use_cor   = 1'b1;
                cor_angle = 34'(t_reg >>> 1);
            end
            ST_XM: begin
                use_mul  = 1'b1;
                mul_a    = 64'(ds_reg);
                mul_b    = 34'(chord_reg);
                mul_nbit = 6'd28;
            end
            ST_XO: begin
                use_mul  = 1'b1;
                mul_a    = 64'(soff_reg);
                mul_b    = 34'(chord_reg);
                mul_nbit = 6'd28;
            end
            ST_YM: begin
                use_mul  = 1'b1;
                mul_a    = (mode_reg == MODE_LEFT) ? 64'(dl_reg) : 64'(dr_reg);
                mul_b    = 34'(chord_reg);
                mul_nbit = 6'd28;
            end
            ST_YO: begin
                use_mul  = 1'b1;
                mul_a    = (mode_reg == MODE_LEFT) ? 64'($signed({1'b0, loff_reg}))
                                                   : 64'($signed({1'b0, roff_reg}));
                mul_b    = 34'(chord_reg);
                mul_nbit = 6'd28;
            end
            ST_XD, ST_YD: begin
                use_div = 1'b1;
                div_num = prod_reg;
                div_den = 34'(t_reg);
            end
            ST_MID: begin
                use_cor   = 1'b1;
                cor_angle = 34'(h_reg) - 34'(t_reg >>> 1);
            end
            ST_G1, ST_G4: begin
                use_mul  = 1'b1;
                mul_a    = (state_reg == ST_G1) ? 64'(ly_reg) : 64'(lx_reg);
                mul_b    = 34'(cos_reg);
                mul_nbit = 6'd27;
            end
            ST_G2, ST_G3: begin
                use_mul  = 1'b1;
                mul_a    = (state_reg == ST_G2) ? 64'(lx_reg) : 64'(ly_reg);
                mul_b    = 34'(sin_reg);
                mul_nbit = 6'd27;
            end
            ST_DEG: begin
                use_mul  = 1'b1;
                mul_a    = 64'(h_reg);
                mul_b    = 34'(RAD2DEG_Q16);
                mul_nbit = 6'd22;
            end
            default: begin
                use_mul = 1'b0;
            end
        endcase
    end

    // launch a unit on the first cycle of its step
    assign mul_start = use_mul && !launched_reg;
    assign div_start = use_div && !launched_reg;
    assign cor_start = use_cor && !launched_reg;
    assign unit_done = mul_stat.done || div_stat.done || cor_stat.done;

    twodo_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .nbit    (mul_nbit),
        .prod    (mul_p),
        .stat    (mul_stat)
    );

    twodo_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_q),
        .stat    (div_stat)
    );

    twodo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (cor_angle),
        .cos_q   (cor_c),
        .sin_q   (cor_s),
        .stat    (cor_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_MOTORS;
            radius_reg       <= 17'd3329;
            loff_reg         <= 21'd9830;
            roff_reg         <= 21'd9830;
            soff_reg         <= 22'sd0;
            sx_reg           <= 32'sd0;
            sy_reg           <= 32'sd0;
            sh_reg           <= 32'sd0;
            clr_pend_reg     <= 1'b0;
            last_left_reg    <= 32'sd0;
            last_right_reg   <= 32'sd0;
            last_side_reg    <= 32'sd0;
            sum_left_reg     <= 32'sd0;
            sum_right_reg    <= 32'sd0;
            last_heading_reg <= 32'sd0;
            acc_x_reg        <= 32'sd0;
            acc_y_reg        <= 32'sd0;
            state_reg        <= ST_IDLE;
            launched_reg     <= 1'b0;
            wheel_reg        <= 2'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            // register write: store now, restart the pose next cycle
            clr_pend_reg <= cfg_we;
            if (cfg_we) begin
                unique case (paddr[4:2])
                    REG_MODE:    mode_reg   <= pwdata[1:0];
                    REG_RADIUS:  radius_reg <= pwdata[16:0];
                    REG_LOFF:    loff_reg   <= pwdata[20:0];
                    REG_ROFF:    roff_reg   <= pwdata[20:0];
                    REG_SOFF:    soff_reg   <= $signed(pwdata[21:0]);
                    REG_START_X: sx_reg     <= $signed(pwdata);
                    REG_START_Y: sy_reg     <= $signed(pwdata);
                    REG_START_H: sh_reg     <= $signed(pwdata);
                    default:     mode_reg   <= mode_reg;
                endcase
            end
            if (clr_pend_reg) begin
                last_left_reg    <= 32'sd0;
                last_right_reg   <= 32'sd0;
                last_side_reg    <= 32'sd0;
                sum_left_reg     <= 32'sd0;
                sum_right_reg    <= 32'sd0;
                last_heading_reg <= sh_reg;
                acc_x_reg        <= sx_reg;
                acc_y_reg        <= sy_reg;
            end

            if (mul_start || div_start || cor_start) begin
                launched_reg <= 1'b1;
            end
            if (unit_done) begin
                launched_reg <= 1'b0;
            end

            // drop the result once it is taken; a new push overrides below
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        // unused wheel reads as zero
                        in_l_reg  <= (mode_reg == MODE_RIGHT) ? 32'sd0 : s_left_angle;
                        in_r_reg  <= (mode_reg == MODE_LEFT) ? 32'sd0 : s_right_angle;
                        in_s_reg  <= s_side_angle;
                        in_ga_reg <= s_gyro_a;
                        in_gb_reg <= s_gyro_b;
                        wheel_reg <= 2'd0;
                        state_reg <= ST_TRAV_A;
                    end
                end
                ST_TRAV_A: begin
                    if (unit_done) begin
                        prod_reg  <= mul_p;
                        state_reg <= ST_TRAV_B;
                    end
                end
                ST_TRAV_B: begin
                    if (unit_done) begin
                        unique case (wheel_reg)
                            2'd0: begin
                                dl_reg        <= trav;
                                last_left_reg <= in_l_reg;
                                wheel_reg     <= 2'd1;
                                state_reg     <= ST_TRAV_A;
                            end
                            2'd1: begin
                                dr_reg         <= trav;
                                last_right_reg <= in_r_reg;
                                wheel_reg      <= 2'd2;
                                state_reg      <= ST_TRAV_A;
                            end
                            default: begin
                                ds_reg        <= trav;
                                last_side_reg <= in_s_reg;
                                state_reg     <= ST_SUMS;
                            end
                        endcase
                    end
                end
                ST_SUMS: begin
                    sum_left_reg  <= sat32(64'(sum_left_reg) + 64'(dl_reg));
                    sum_right_reg <= sat32(64'(sum_right_reg) + 64'(dr_reg));
                    if (mode_reg == MODE_THREE) begin
                        // zero track width: hold the start heading
                        if (track == 22'd0) begin
                            h_reg     <= sh_reg;
                            state_reg <= ST_TURN;
                        end else begin
                            state_reg <= ST_HDIV;
                        end
                    end else begin
                        state_reg <= ST_GYRO;
                    end
                end
                ST_GYRO: begin
                    if (unit_done) begin
                        h_reg     <= sat32(64'(sh_reg) + (mul_p >>> 9));
                        state_reg <= ST_TURN;
                    end
                end
                ST_HDIV: begin
                    if (unit_done) begin
                        h_reg     <= sat32(64'(sh_reg) + div_q);
                        state_reg <= ST_TURN;
                    end
                end
                ST_TURN: begin
                    t_reg            <= turn;
                    last_heading_reg <= h_reg;
                    if (turn == 33'sd0) begin
                        // straight move
                        lx_reg    <= ds_reg;
                        ly_reg    <= (mode_reg == MODE_RIGHT) ? dr_reg : dl_reg;
                        state_reg <= ST_MID;
                    end else begin
                        state_reg <= ST_HALF;
                    end
                end
                ST_HALF: begin
                    if (unit_done) begin
                        chord_reg <= {cor_s, 1'b0};
                        state_reg <= ST_XM;
                    end
                end
                ST_XM, ST_YM: begin
                    if (unit_done) begin
                        prod_reg  <= mul_p;
                        state_reg <= (state_reg == ST_XM) ? ST_XD : ST_YD;
                    end
                end
                ST_XD, ST_YD: begin
                    if (unit_done) begin
                        q_reg     <= div_q;
                        state_reg <= (state_reg == ST_XD) ? ST_XO : ST_YO;
                    end
                end
                ST_XO: begin
                    if (unit_done) begin
                        lx_reg    <= sat32(q_reg - (mul_p >>> 24));
                        state_reg <= ST_YM;
                    end
                end
                ST_YO: begin
                    if (unit_done) begin
                        if (mode_reg == MODE_LEFT) begin
                            ly_reg <= sat32(q_reg - (mul_p >>> 24));
                        end else begin
                            ly_reg <= sat32(q_reg + (mul_p >>> 24));
                        end
                        state_reg <= ST_MID;
                    end
                end
                ST_MID: begin
                    if (unit_done) begin
                        cos_reg   <= cor_c;
                        sin_reg   <= cor_s;
                        state_reg <= ST_G1;
                    end
                end
                ST_G1, ST_G3: begin
                    if (unit_done) begin
                        prod_reg  <= mul_p;
                        state_reg <= (state_reg == ST_G1) ? ST_G2 : ST_G4;
                    end
                end
                ST_G2: begin
                    if (unit_done) begin
                        acc_x_reg <= sat32(64'(acc_x_reg) + ((prod_reg - mul_p) >>> 24));
                        state_reg <= ST_G3;
                    end
                end
                ST_G4: begin
                    if (unit_done) begin
                        acc_y_reg <= sat32(64'(acc_y_reg) + ((prod_reg + mul_p) >>> 24));
                        state_reg <= ST_DEG;
                    end
                end
                ST_DEG: begin
                    if (unit_done) begin
                        deg_reg   <= sat32(mul_p >>> 24);
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg       <= 1'b1;
                        m_pos_x_reg       <= acc_x_reg;
                        m_pos_y_reg       <= acc_y_reg;
                        m_heading_deg_reg <= deg_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE) && !clr_pend_reg;
    assign m_valid       = m_valid_reg;
    assign m_pos_x       = m_pos_x_reg;
    assign m_pos_y       = m_pos_y_reg;
    assign m_heading_deg = m_heading_deg_reg;

    // only one arithmetic unit runs at a time
    a_one_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({mul_stat.busy, div_stat.busy, cor_stat.busy}))
        else $error("more than one arithmetic unit busy");

    // a result beat appears only from the push step
    a_push_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_PUSH)
        else $error("result raised outside push step");

    // an accepted sample starts with the left wheel travel
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_TRAV_A && wheel_reg == 2'd0))
        else $error("sample accepted without starting travel");

endmodule
